>>> rtl/pearson_correlation_stream_unit_macros.svh
// assertion macros for the pearson correlation stream unit
`ifndef PEARSON_CORRELATION_STREAM_UNIT_MACROS_SVH
`define PEARSON_CORRELATION_STREAM_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// property checked at every rising clock edge outside reset
`define PCS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("pcs check failed");
// consequent checked in the cycle after the antecedent
`define PCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("pcs check failed");
`else
`define PCS_ASSERT(lbl, clk, rst, prop)
`define PCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/pcs_pkg.sv
// shared types and codes of the pearson correlation stream unit
package pcs_pkg;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_VAR = 2'd1;
  localparam logic [1:0] STAT_TOO_MANY = 2'd2;

  // fixed field widths
  localparam int SAMPLE_W = 8;
  localparam int CORR_W   = 16;
  localparam int ROOT_W   = 31;

  // finalization sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_START, S_MUL, S_POST, S_NEG, S_DIV, S_SQRT, S_FIN
  } pcs_state_t;

  // which product the shared multiply is working on
  typedef enum logic [2:0] {
    PH_MXX, PH_XX, PH_MYY, PH_YY, PH_MXY, PH_XY, PH_MAG2, PH_DEN
  } pcs_phase_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] corr;
    logic [1:0]               status;
  } pcs_result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pcs_eng_stat_t;

endpackage

>>> rtl/pcs_addsub.sv
// shared add / subtract unit with carry out (carry set means a >= b on subtract)
module pcs_addsub #(
  parameter int W = 85
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);
  logic [W-1:0] b_eff;

  // invert b and add one for subtraction
  assign b_eff = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + (W+1)'(sub);
endmodule

>>> rtl/pcs_engine.sv
// finalization sequencer: serial multiplies, restoring divide and integer root
module pcs_engine #(
  parameter int CW = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 ovf,
  input  logic                 out_free,
  input  logic [CW-1:0]        m,
  input  logic [CW+7:0]        sx,
  input  logic [CW+7:0]        sy,
  input  logic [CW+15:0]       sxx,
  input  logic [CW+15:0]       syy,
  input  logic [CW+15:0]       sxy,
  output pcs_pkg::pcs_eng_stat_t stat,
  output pcs_pkg::pcs_result_t   result
);
  import pcs_pkg::*;

  localparam int VW = 2*CW + 16;
  localparam int DW = 2*VW;
  localparam int AW = DW + 1;

  pcs_state_t state, state_next;
  pcs_phase_t phase;

  logic [DW-1:0]     mcand, acc, t0, den, rem;
  logic [VW-1:0]     mplier, vx, vy;
  logic              neg, first;
  logic [4:0]        cnt;
  logic [ROOT_W-1:0] q, op, res, one;
  logic [1:0]        status;

  logic [AW-1:0]     add_a, add_b, add_sum, cand;
  logic              add_sub, add_carry;
  logic              zero_var;
  logic [CORR_W-1:0] lo;

  pcs_addsub #(.W(AW)) u_addsub (
    .a(add_a), .b(add_b), .sub(add_sub), .sum(add_sum), .carry(add_carry)
  );

  assign cand     = first ? {1'b0, rem} : {rem, 1'b0};
  assign zero_var = (vx == '0) || (add_sum[VW-1:0] == '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_LOAD;
      S_LOAD:  state_next = ovf ? S_FIN : S_START;
      S_START: state_next = S_MUL;
      S_MUL:   if (mplier == '0) state_next = S_POST;
      S_POST: begin
        case (phase)
          PH_YY:   state_next = zero_var ? S_FIN : S_START;
          PH_XY:   state_next = add_carry ? S_START : S_NEG;
          PH_DEN:  state_next = S_DIV;
          default: state_next = S_START;
        endcase
      end
      S_NEG:   state_next = S_START;
      S_DIV:   if (cnt == '0) state_next = S_SQRT;
      S_SQRT:  if (one[0]) state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // shared unit operands and handshake outputs
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b1;
    case (state)
      S_MUL: begin
        add_a   = AW'(acc);
        add_b   = AW'(mcand);
        add_sub = 1'b0;
      end
      S_POST: begin
        add_a = AW'(t0);
        add_b = AW'(acc);
      end
      S_NEG:  add_b = AW'(t0);
      S_DIV: begin
        add_a = cand;
        add_b = AW'(den);
      end
      S_SQRT: begin
        add_a = AW'(op);
        add_b = AW'(res | one);
      end
      default: add_sub = 1'b1;
    endcase
    stat.busy = (state != S_IDLE);
    stat.done = (state == S_FIN) && out_free;
  end

  // result formatting: sign and saturation at plus one
  assign lo = res[CORR_W-1:0];
  always_comb begin
    result.status = status;
    if (neg) result.corr = CORR_W'(~lo + CORR_W'(1));
    else     result.corr = lo[CORR_W-1] ? {1'b0, {(CORR_W-1){1'b1}}} : lo;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        phase  <= PH_MXX;
        neg    <= 1'b0;
        res    <= '0;
        status <= ovf ? STAT_TOO_MANY : STAT_OK;
      end
      S_START: begin
        acc <= '0;
        case (phase)
          PH_MXX:  begin mcand <= DW'(sxx); mplier <= VW'(m);  end
          PH_XX:   begin mcand <= DW'(sx);  mplier <= VW'(sx); end
          PH_MYY:  begin mcand <= DW'(syy); mplier <= VW'(m);  end
          PH_YY:   begin mcand <= DW'(sy);  mplier <= VW'(sy); end
          PH_MXY:  begin mcand <= DW'(sxy); mplier <= VW'(m);  end
          PH_XY:   begin mcand <= DW'(sx);  mplier <= VW'(sy); end
          PH_MAG2: begin mcand <= DW'(t0[VW-1:0]); mplier <= t0[VW-1:0]; end
          default: begin mcand <= DW'(vx);  mplier <= vy;      end
        endcase
      end
      // shift-add multiply, one multiplier bit a cycle
      S_MUL: begin
        if (mplier[0]) acc <= add_sum[DW-1:0];
        mcand  <= {mcand[DW-2:0], 1'b0};
        mplier <= {1'b0, mplier[VW-1:1]};
      end
      S_POST: begin
        case (phase)
          PH_MXX:  begin t0 <= acc; phase <= PH_XX; end
          PH_XX:   begin vx <= add_sum[VW-1:0]; phase <= PH_MYY; end
          PH_MYY:  begin t0 <= acc; phase <= PH_YY; end
          PH_YY: begin
            vy    <= add_sum[VW-1:0];
            phase <= PH_MXY;
            if (zero_var) status <= STAT_ZERO_VAR;
          end
          PH_MXY:  begin t0 <= acc; phase <= PH_XY; end
          PH_XY: begin
            t0    <= DW'(add_sum[VW-1:0]);
            neg   <= ~add_carry;
            phase <= PH_MAG2;
          end
          PH_MAG2: begin t0 <= acc; phase <= PH_DEN; end
          default: begin
            den   <= acc;
            rem   <= t0;
            first <= 1'b1;
            cnt   <= 5'd30;
          end
        endcase
      end
      // negative covariance: take the magnitude
      S_NEG: t0 <= DW'(add_sum[VW-1:0]);
      // restoring divide of mag^2 * 2^30 by the variance product
      S_DIV: begin
        rem   <= add_carry ? add_sum[DW-1:0] : cand[DW-1:0];
        q     <= {q[ROOT_W-2:0], add_carry};
        first <= 1'b0;
        cnt   <= cnt - 5'd1;
        if (cnt == '0) begin
          op  <= {q[ROOT_W-2:0], add_carry};
          res <= '0;
          one <= {1'b1, {(ROOT_W-1){1'b0}}};
        end
      end
      // digit-by-digit integer square root
      S_SQRT: begin
        if (add_carry) begin
          op  <= add_sum[ROOT_W-1:0];
          res <= {1'b0, res[ROOT_W-1:1]} | one;
        end else begin
          res <= {1'b0, res[ROOT_W-1:1]};
        end
        one <= {2'b00, one[ROOT_W-1:2]};
      end
      default: acc <= acc;
    endcase
  end
endmodule

>>> rtl/pearson_correlation_stream_unit.sv
// top level of the pearson correlation stream unit: accumulation and result register
//
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   x_sample, y_sample, last
// out      from block out_valid / out_stall correlation, status
//
// a pair without last is taken every cycle while no finalization runs. a pair
// with last starts the finalization, which holds in_stall through eight serial
// multiplies, each running over the bits of its multiplier, an extra negate
// step for a negative covariance, the divide and the root.
// zero variance or too many samples ends it early. the one shared
// add/subtract unit does the serial multiplies, a 31-step divide and a
// 16-step root. the result sits in an output register, so out_stall holds
// only that register; finalization of the next column waits for it.
// rst is synchronous and clears counts, sums and valid flags.
module pearson_correlation_stream_unit #(
  parameter int MAX_PAIRS = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               x_sample,
  input  logic [7:0]               y_sample,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       correlation,
  output logic [1:0]               status
);
  import pcs_pkg::*;
  `include "pearson_correlation_stream_unit_macros.svh"

  localparam int CW  = $clog2(MAX_PAIRS + 1);
  localparam int SXW = CW + 8;
  localparam int SQW = CW + 16;

  logic [CW-1:0]  pair_count;
  logic [SXW-1:0] sum_x, sum_y;
  logic [SQW-1:0] sum_xx, sum_yy, sum_xy;
  logic           overflow_seen;

  logic           accept, room, out_free;
  logic [15:0]    xx, yy, xy;
  pcs_eng_stat_t  eng_stat;
  pcs_result_t    eng_result;

  assign accept   = in_valid && !in_stall;
  assign in_stall = eng_stat.busy;
  assign room     = pair_count < CW'(MAX_PAIRS);
  assign out_free = !out_valid || !out_stall;
  assign xx       = x_sample * x_sample;
  assign yy       = y_sample * y_sample;
  assign xy       = x_sample * y_sample;

  pcs_engine #(.CW(CW)) u_engine (
    .clk(clk), .rst(rst),
    .start(accept && last), .ovf(overflow_seen), .out_free(out_free),
    .m(pair_count), .sx(sum_x), .sy(sum_y),
    .sxx(sum_xx), .syy(sum_yy), .sxy(sum_xy),
    .stat(eng_stat), .result(eng_result)
  );

  // running sums, cleared once a result leaves the engine
  always_ff @(posedge clk) begin
    if (rst || eng_stat.done) begin
      pair_count    <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_xx        <= '0;
      sum_yy        <= '0;
      sum_xy        <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (room) begin
        pair_count <= pair_count + CW'(1);
        sum_x      <= sum_x + SXW'(x_sample);
        sum_y      <= sum_y + SXW'(y_sample);
        sum_xx     <= sum_xx + SQW'(xx);
        sum_yy     <= sum_yy + SQW'(yy);
        sum_xy     <= sum_xy + SQW'(xy);
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_stat.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_stat.done) begin
      correlation <= eng_result.corr;
      status      <= eng_result.status;
    end
  end

  `PCS_ASSERT(a_count_bound, clk, rst, pair_count <= CW'(MAX_PAIRS))
  `PCS_ASSERT_NEXT(a_clear_after_done, clk, rst, eng_stat.done, pair_count == '0 && !overflow_seen)
  `PCS_ASSERT(a_done_needs_room, clk, rst, !eng_stat.done || out_free)
  `PCS_ASSERT(a_special_zero, clk, rst, !(out_valid && status != STAT_OK) || correlation == '0)
endmodule

>>> verif/pcs_checker.sv
// checker for the pearson correlation stream unit: coefficient predictor and result compare
`timescale 1ns / 100ps
module pcs_checker #(
  parameter int MAX_PAIRS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         x_sample,
  input  logic [7:0]         y_sample,
  input  logic               last,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] correlation,
  input  logic [1:0]         status,
  output int                 errors,
  output int                 pending
);
  import pcs_pkg::*;

  // running column sums of the predictor
  logic [63:0] n_pairs, acc_x, acc_y, acc_xx, acc_yy, acc_xy;
  logic        too_many;
  pcs_result_t expected_q[$];
  int          n_pred, n_seen;

  // exact coefficient from the column sums, magnitude truncated to q1.15
  function automatic pcs_result_t column_coefficient(
    input logic [63:0] nc, input logic [63:0] sx, input logic [63:0] sy,
    input logic [63:0] sxx, input logic [63:0] syy, input logic [63:0] sxy,
    input logic ov
  );
    pcs_result_t r;
    logic [63:0]  var_x, var_y, pa, pb, mag, lo, hi, mid;
    logic [127:0] rhs, den;
    logic         neg;
    r.corr = '0;
    r.status = STAT_OK;
    if (ov) begin
      r.status = STAT_TOO_MANY;
      return r;
    end
    var_x = nc * sxx - sx * sx;
    var_y = nc * syy - sy * sy;
    if (var_x == 0 || var_y == 0) begin
      r.status = STAT_ZERO_VAR;
      return r;
    end
    pa = nc * sxy;
    pb = sx * sy;
    neg = pa < pb;
    mag = neg ? pb - pa : pa - pb;
    rhs = ({64'd0, mag} * {64'd0, mag}) << 30;
    den = {64'd0, var_x} * {64'd0, var_y};
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (den * {64'd0, mid * mid} <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (neg) r.corr = -$signed(lo[15:0]);
    else r.corr = (lo > 32767) ? 16'sd32767 : lo[15:0];
    return r;
  endfunction

  // accumulate accepted pairs and queue a prediction on each last pair
  always @(posedge clk) begin
    if (rst) begin
      n_pairs <= 0; acc_x <= 0; acc_y <= 0; acc_xx <= 0; acc_yy <= 0; acc_xy <= 0;
      too_many <= 0;
      n_pred <= 0;
    end else if (in_valid && !in_stall) begin
      logic [63:0] nx, ny, nc, sx, sy, sxx, syy, sxy;
      logic        ov;
      nx = x_sample; ny = y_sample;
      nc = n_pairs; sx = acc_x; sy = acc_y; sxx = acc_xx; syy = acc_yy; sxy = acc_xy;
      ov = too_many;
      if (nc >= MAX_PAIRS) ov = 1;
      else begin
        nc++; sx += nx; sy += ny; sxx += nx * nx; syy += ny * ny; sxy += nx * ny;
      end
      if (last) begin
        expected_q.push_back(column_coefficient(nc, sx, sy, sxx, syy, sxy, ov));
        n_pred <= n_pred + 1;
        n_pairs <= 0; acc_x <= 0; acc_y <= 0; acc_xx <= 0; acc_yy <= 0; acc_xy <= 0;
        too_many <= 0;
      end else begin
        n_pairs <= nc; acc_x <= sx; acc_y <= sy; acc_xx <= sxx; acc_yy <= syy;
        acc_xy <= sxy; too_many <= ov;
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      n_seen <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result corr=%0d status=%0d", $time, correlation, status);
      end else begin
        pcs_result_t e;
        e = expected_q.pop_front();
        n_seen <= n_seen + 1;
        if (correlation !== e.corr) begin
          errors++;
          $display("%0t: correlation expected %0d actual %0d", $time, e.corr, correlation);
        end
        if (status !== e.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        end
      end
    end
  end

  // predictions still waiting for their result
  assign pending = n_pred - n_seen;

endmodule

>>> verif/testbench.sv
// testbench top: stimulus, idling, hold-off and verdict for the correlation unit
`timescale 1ns / 100ps
module testbench;
  import pcs_pkg::*;

  logic               clk = 0, rst = 1;
  logic               in_valid = 0, in_stall;
  logic [7:0]         x_sample = 0, y_sample = 0;
  logic               last = 0;
  logic               out_valid, out_stall = 0;
  logic signed [15:0] correlation;
  logic [1:0]         status;
  int                 errors, pending;
  int                 send_idle = 0, recv_idle = 0;
  bit                 hold_go = 0, hold_done = 0;
  int                 hold_left = 0;

  pearson_correlation_stream_unit dut (.*);
  pcs_checker chk (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // receiver: random stall plus one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
      if (hold_left == 1) hold_done <= 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1;
      hold_left <= 3000;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // offer one pair and wait for its transaction
  task automatic send_pair(input logic [7:0] xv, input logic [7:0] yv, input logic lst);
    logic s;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    x_sample <= xv;
    y_sample <= yv;
    last <= lst;
    forever begin
      @(negedge clk);
      s = in_stall;
      @(posedge clk);
      if (!s) break;
    end
  endtask

  // random column of n pairs; mode picks the shape of the data
  task automatic send_column(input int n, input int mode);
    logic [7:0] xv, yv, c;
    int         a;
    c = 8'($urandom);
    a = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      xv = 8'($urandom);
      case (mode)
        0: yv = 8'($urandom);
        1: yv = xv;
        2: yv = ~xv;
        3: yv = c;
        4: yv = 8'((xv / a) ^ ($urandom_range(7)));
        default: yv = 8'(255 - xv / a);
      endcase
      send_pair(xv, yv, i == n - 1);
    end
  endtask

  task automatic random_phase(input int items);
    int n, sent;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(15) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      send_column(n, $urandom_range(5));
      sent += n;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: single pair, extremes, exact plus and minus one, flat columns
    send_pair(8'd255, 8'd0, 1);
    send_pair(8'd0, 8'd0, 0);   send_pair(8'd255, 8'd255, 1);
    send_pair(8'd0, 8'd255, 0); send_pair(8'd255, 8'd0, 1);
    send_pair(8'd7, 8'd1, 0);   send_pair(8'd7, 8'd200, 1);
    send_pair(8'd3, 8'd9, 0);   send_pair(8'd90, 8'd9, 1);
    send_pair(8'd1, 8'd2, 0);   send_pair(8'd2, 8'd4, 0); send_pair(8'd200, 8'd255, 1);
    send_pair(8'd10, 8'd0, 0);  send_pair(8'd20, 8'd128, 0);
    send_pair(8'd30, 8'd255, 0); send_pair(8'd40, 8'd17, 1);

    send_idle = 31; recv_idle = 45;
    random_phase(500);
    // long receiver hold-off while pairs keep coming
    hold_go = 1;
    random_phase(150);
    in_valid <= 0;
    wait (hold_done);
    // sender pauses until all results are in
    wait (pending == 0);
    send_idle = 45; recv_idle = 31;
    random_phase(500);
    send_idle = 0; recv_idle = 0;
    random_phase(600);
    in_valid <= 0;

    @(posedge clk);
    wait (pending == 0);
    repeat (500) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/pcs_pkg.sv
rtl/pcs_addsub.sv
rtl/pcs_engine.sv
rtl/pearson_correlation_stream_unit.sv
verif/pcs_checker.sv
verif/testbench.sv
